### rtl/rgbyuv_pkg.sv
// Shared types, constants and arithmetic helpers for the RGB to YUV 4:2:0 converter.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package rgbyuv_pkg;

    // Geometry and storage defaults
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths
    localparam int COMP_W      = 8;
    localparam int ROW_WIDTH_W = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int SUM_W       = 18;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH  = 4'd0,
        REG_FULL_RANGE = 4'd1
    } reg_idx_t;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;

    // Studio range (BT.601) coefficients
    localparam logic signed [SUM_W-1:0] YS_R  = 18'sd66;
    localparam logic signed [SUM_W-1:0] YS_G  = 18'sd129;
    localparam logic signed [SUM_W-1:0] YS_B  = 18'sd25;
    localparam logic signed [SUM_W-1:0] YS_OF = 18'sh01080;
    localparam logic signed [SUM_W-1:0] CS_HI = 18'sd112;
    localparam logic signed [SUM_W-1:0] US_G  = 18'sd74;
    localparam logic signed [SUM_W-1:0] US_R  = 18'sd38;
    localparam logic signed [SUM_W-1:0] VS_G  = 18'sd94;
    localparam logic signed [SUM_W-1:0] VS_B  = 18'sd18;
    localparam logic signed [SUM_W-1:0] CS_OF = 18'sh08000;

    // Full range (JPEG) coefficients
    localparam logic signed [SUM_W-1:0] YF_R  = 18'sd38;
    localparam logic signed [SUM_W-1:0] YF_G  = 18'sd75;
    localparam logic signed [SUM_W-1:0] YF_B  = 18'sd15;
    localparam logic signed [SUM_W-1:0] YF_OF = 18'sd64;
    localparam logic signed [SUM_W-1:0] CF_HI = 18'sd127;
    localparam logic signed [SUM_W-1:0] UF_G  = 18'sd84;
    localparam logic signed [SUM_W-1:0] UF_R  = 18'sd43;
    localparam logic signed [SUM_W-1:0] VF_G  = 18'sd107;
    localparam logic signed [SUM_W-1:0] VF_B  = 18'sd20;
    localparam logic signed [SUM_W-1:0] CF_OF = 18'sh08080;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0] row_width;
        logic                   full_range;
    } cfg_t;

    // Classification made by the front end
    typedef struct packed {
        logic odd_row;
        logic col_odd;
        logic last;
    } flags_t;

    // One queued pixel with the stored pixel above it
    typedef struct packed {
        rgb_t   pix;
        rgb_t   above;
        flags_t flags;
    } job_t;

    typedef struct packed {
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
    } chroma_t;

    // Rounded average of two components
    function automatic logic [COMP_W-1:0] avg8(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
        logic [COMP_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{COMP_W{1'b0}}, 1'b1};
        return sum[COMP_W:1];
    endfunction

    function automatic rgb_t avg_pixel(rgb_t p, rgb_t q);
        rgb_t res;
        res.red   = avg8(p.red, q.red);
        res.green = avg8(p.green, q.green);
        res.blue  = avg8(p.blue, q.blue);
        return res;
    endfunction

    function automatic logic [COMP_W-1:0] calc_luma(rgb_t p, logic full);
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] s;
        logic [COMP_W-1:0]       y;
        r = $signed({{(SUM_W-COMP_W){1'b0}}, p.red});
        g = $signed({{(SUM_W-COMP_W){1'b0}}, p.green});
        b = $signed({{(SUM_W-COMP_W){1'b0}}, p.blue});
        if (full)
        begin
            s = YF_R * r + YF_G * g + YF_B * b + YF_OF;
            y = s[14:7];
        end
        else
        begin
            s = YS_R * r + YS_G * g + YS_B * b + YS_OF;
            y = s[15:8];
        end
        return y;
    endfunction

    // Both sums stay positive and below 2^16 for 8-bit components
    function automatic chroma_t calc_chroma(rgb_t p, logic full);
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] g;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] su;
        logic signed [SUM_W-1:0] sv;
        chroma_t                 res;
        r = $signed({{(SUM_W-COMP_W){1'b0}}, p.red});
        g = $signed({{(SUM_W-COMP_W){1'b0}}, p.green});
        b = $signed({{(SUM_W-COMP_W){1'b0}}, p.blue});
        if (full)
        begin
            su = CF_HI * b - UF_G * g - UF_R * r + CF_OF;
            sv = CF_HI * r - VF_G * g - VF_B * b + CF_OF;
        end
        else
        begin
            su = CS_HI * b - US_G * g - US_R * r + CS_OF;
            sv = CS_HI * r - VS_G * g - VS_B * b + CS_OF;
        end
        res.cb = su[15:8];
        res.cr = sv[15:8];
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/rgbyuv_pix_if.sv
// Pixel channel: valid/ready handshake carrying one RGB pixel.
// Depends on rgbyuv_pkg for component widths.
`default_nettype none

interface rgbyuv_pix_if;
    logic                             valid;
    logic                             ready;
    logic [rgbyuv_pkg::COMP_W-1:0]    red;
    logic [rgbyuv_pkg::COMP_W-1:0]    green;
    logic [rgbyuv_pkg::COMP_W-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/rgbyuv_res_if.sv
// Result channel: valid/ready handshake carrying luma, block chroma and row end.
// Depends on rgbyuv_pkg for component widths.
`default_nettype none

interface rgbyuv_res_if;
    logic                             valid;
    logic                             ready;
    logic [rgbyuv_pkg::COMP_W-1:0]    luma;
    logic                             chroma_valid;
    logic [rgbyuv_pkg::COMP_W-1:0]    cb;
    logic [rgbyuv_pkg::COMP_W-1:0]    cr;
    logic                             row_end;

    modport source (output valid, output luma, output chroma_valid, output cb, output cr,
                    output row_end, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input cb, input cr,
                    input row_end, output ready);
endinterface

`default_nettype wire

### rtl/rgbyuv_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on rgbyuv_pkg for index and data widths.
`default_nettype none

interface rgbyuv_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rgbyuv_pkg::CFG_IDX_W-1:0]     index;
    logic [rgbyuv_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/rgbyuv_front.sv
// Front end: accepts pixels, tracks column and row parity, owns the line buffer.
// Depends on rgbyuv_pkg and rgbyuv_pix_if; feeds classified jobs to the queue.
`default_nettype none

module rgbyuv_front #(
    parameter int MAX_WIDTH = rgbyuv_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    rgbyuv_pix_if.sink         pixels,
    input  rgbyuv_pkg::cfg_t   cfg,
    output logic               push_valid,
    input  logic               push_ready,
    output rgbyuv_pkg::job_t   push_job
);
    import rgbyuv_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (ROW_WIDTH_W > CW + 1) ? ROW_WIDTH_W : CW + 1;

    logic [CW-1:0] column_reg, column_next;
    logic          odd_row_reg, odd_row_next;
    logic          s1_valid_reg, s1_valid_next;
    rgb_t          s1_pix_reg;
    flags_t        s1_flags_reg;
    rgb_t          above_reg;
    rgb_t          line_mem [MAX_WIDTH];

    logic [WW-1:0] width_ext, eff_width, col_plus;
    logic          accept, last;
    rgb_t          pixel;

    assign pixel = '{red: pixels.red, green: pixels.green, blue: pixels.blue};

    // Stage 1 can take a pixel when empty or when it drains this cycle
    assign pixels.ready = !s1_valid_reg || push_ready;
    assign accept       = pixels.valid && pixels.ready;

    // Effective row width: zero acts as one, clamp to buffer depth
    always_comb
    begin
        width_ext = WW'(cfg.row_width);
        if (width_ext == '0)
            eff_width = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = width_ext;
        col_plus = WW'(column_reg) + WW'(1);
        last     = (col_plus >= eff_width);
    end

    // Position tracking
    always_comb
    begin
        column_next  = column_reg;
        odd_row_next = odd_row_reg;
        if (accept)
        begin
            if (last)
            begin
                column_next  = '0;
                odd_row_next = !odd_row_reg;
            end
            else
            begin
                column_next = column_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            odd_row_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg   <= column_next;
            odd_row_reg  <= odd_row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg           <= pixel;
            s1_flags_reg.odd_row <= odd_row_reg;
            s1_flags_reg.col_odd <= column_reg[0];
            s1_flags_reg.last    <= last;
        end
    end

    // Line buffer: even rows write, odd rows read the pixel above
    always_ff @(posedge clk)
    begin
        if (accept && !odd_row_reg)
            line_mem[column_reg] <= pixel;
        if (accept && odd_row_reg)
            above_reg <= line_mem[column_reg];
    end

    assign push_valid     = s1_valid_reg;
    assign push_job.pix   = s1_pix_reg;
    assign push_job.above = above_reg;
    assign push_job.flags = s1_flags_reg;

endmodule

`default_nettype wire

### rtl/rgbyuv_queue.sv
// Short job queue between front end and back end, built from flip-flops.
// Depends on rgbyuv_pkg for the job type.
`default_nettype none

module rgbyuv_queue #(
    parameter int DEPTH = rgbyuv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rgbyuv_pkg::job_t   in_job,
    output logic               out_valid,
    input  logic               out_ready,
    output rgbyuv_pkg::job_t   out_job
);
    import rgbyuv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= in_job;
    end

endmodule

`default_nettype wire

### rtl/rgbyuv_back.sv
// Back end: 2x2 averaging with held even-column average, then luma and chroma math.
// Depends on rgbyuv_pkg and rgbyuv_res_if; drains jobs from the queue.
`default_nettype none

module rgbyuv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rgbyuv_pkg::job_t   pop_job,
    input  logic               full_range,
    rgbyuv_res_if.source       results
);
    import rgbyuv_pkg::*;

    // Averaging stage
    logic    a_valid_reg, a_valid_next;
    rgb_t    a_pix_reg;
    rgb_t    a_blk_reg;
    logic    a_chroma_reg;
    logic    a_last_reg;
    rgb_t    held_reg, held_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [COMP_W-1:0] luma_reg;
    logic              chroma_valid_reg;
    logic [COMP_W-1:0] cb_reg;
    logic [COMP_W-1:0] cr_reg;
    logic              row_end_reg;

    logic    a_ready, out_ready, pop;
    rgb_t    vert, blk;
    logic    chroma;
    chroma_t chroma_val;

    assign out_ready = !out_valid_reg || results.ready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign pop_ready = a_ready;
    assign pop       = pop_valid && a_ready;

    // Vertical then horizontal average; the even column average is held
    always_comb
    begin
        vert      = avg_pixel(pop_job.above, pop_job.pix);
        blk       = pop_job.flags.col_odd ? avg_pixel(held_reg, vert) : vert;
        chroma    = pop_job.flags.odd_row && (pop_job.flags.col_odd || pop_job.flags.last);
        held_next = held_reg;
        if (pop && pop_job.flags.odd_row && !pop_job.flags.col_odd)
            held_next = vert;
    end

    always_comb
    begin
        a_valid_next = a_ready ? pop_valid : a_valid_reg;
        out_valid_next = out_ready ? a_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_pix_reg    <= pop_job.pix;
            a_blk_reg    <= blk;
            a_chroma_reg <= chroma;
            a_last_reg   <= pop_job.flags.last;
        end
    end

    // Coefficient math into the output register
    assign chroma_val = calc_chroma(a_blk_reg, full_range);

    always_ff @(posedge clk)
    begin
        if (out_ready && a_valid_reg)
        begin
            luma_reg         <= calc_luma(a_pix_reg, full_range);
            chroma_valid_reg <= a_chroma_reg;
            cb_reg           <= a_chroma_reg ? chroma_val.cb : '0;
            cr_reg           <= a_chroma_reg ? chroma_val.cr : '0;
            row_end_reg      <= a_last_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.luma         = luma_reg;
    assign results.chroma_valid = chroma_valid_reg;
    assign results.cb           = cb_reg;
    assign results.cr           = cr_reg;
    assign results.row_end      = row_end_reg;

endmodule

`default_nettype wire

### rtl/rgb_to_yuv420_converter.sv
// Top level of the RGB to YUV 4:2:0 converter: configuration registers and block wiring.
// Depends on rgbyuv_pkg, the channel interfaces, rgbyuv_front, rgbyuv_queue, rgbyuv_back.
`default_nettype none

// Raster RGB pixels go in one per clock while results are taken; every pixel gives one
// result with its luma; on odd rows the second pixel of each horizontal pair also
// carries cb/cr of the rounded 2x2 block average; a last, even column carries cb/cr
// of its rounded vertical average. Sustained rate is one pixel per clock while results
// are taken; at capture the single-port line buffer takes one write (even rows) or one
// registered read (odd rows) per pixel. Each pixel passes capture, job queue, averaging,
// then coefficient math into the output register. The job queue lets input keep flowing
// for a few pixels while results stall. The line buffer holds MAX_WIDTH pixels, has no
// reset and needs no clearing; an odd row wider than the even row before it reads
// unwritten entries and gives undefined chroma. row_width (index 0, 0 acts as 1, clamped
// to MAX_WIDTH) and full_range (index 1) are to be written only while the block is idle.
module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH   = rgbyuv_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rgbyuv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rgbyuv_pix_if.sink    pixels,
    rgbyuv_res_if.source  results,
    rgbyuv_cfg_if.sink    cfg
);
    import rgbyuv_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cfg_write;
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    // Configuration registers, always ready
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                REG_ROW_WIDTH:  cfg_next.row_width  = cfg.data[ROW_WIDTH_W-1:0];
                REG_FULL_RANGE: cfg_next.full_range = cfg.data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width  <= ROW_WIDTH_RESET;
            cfg_reg.full_range <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rgbyuv_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    rgbyuv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    rgbyuv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .full_range (cfg_reg.full_range),
        .results    (results)
    );

endmodule

`default_nettype wire

### rtl/rgbyuv_checker.sv
// Port-level checks for the RGB to YUV 4:2:0 converter, bound to the top level.
// Depends on rgbyuv_pkg for widths; sees only the top level's channel signals.
`default_nettype none

module rgbyuv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_valid,
    input logic                            pix_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [rgbyuv_pkg::COMP_W-1:0]   res_luma,
    input logic                            res_chroma_valid,
    input logic [rgbyuv_pkg::COMP_W-1:0]   res_cb,
    input logic [rgbyuv_pkg::COMP_W-1:0]   res_cr,
    input logic                            res_row_end
);
    import rgbyuv_pkg::*;

    logic [5:0] outstanding_reg, outstanding_next;
    logic       prev_chroma_reg, prev_chroma_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = pix_valid && pix_ready;
    assign out_xfer = res_valid && res_ready;

    // Pixels taken but not yet delivered, and chroma flag of the last result transfer
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_xfer && !out_xfer)
            outstanding_next = outstanding_reg + 6'd1;
        else if (out_xfer && !in_xfer)
            outstanding_next = outstanding_reg - 6'd1;
        prev_chroma_next = out_xfer ? res_chroma_valid : prev_chroma_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            prev_chroma_reg <= 1'b0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            prev_chroma_reg <= prev_chroma_next;
        end
    end

    // No result without a pixel in flight
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> outstanding_reg != 6'd0)
        else $error("result shown with no pixel outstanding");

    // Chroma fields are zero on results without a block
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_chroma_valid |-> res_cb == '0 && res_cr == '0)
        else $error("cb/cr nonzero while chroma_valid is low");

    // Block chroma on two transfers in a row only when the second closes the row
    a_chroma_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && res_chroma_valid && prev_chroma_reg |-> res_row_end)
        else $error("chroma_valid on two consecutive result transfers mid-row");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_luma) && $stable(res_cb)
            && $stable(res_cr) && $stable(res_chroma_valid) && $stable(res_row_end))
        else $error("stalled result changed");

endmodule

bind rgb_to_yuv420_converter rgbyuv_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_valid        (pixels.valid),
    .pix_ready        (pixels.ready),
    .res_valid        (results.valid),
    .res_ready        (results.ready),
    .res_luma         (results.luma),
    .res_chroma_valid (results.chroma_valid),
    .res_cb           (results.cb),
    .res_cr           (results.cr),
    .res_row_end      (results.row_end)
);

`default_nettype wire

### sim/tb.sv
// Testbench for rgb_to_yuv420_converter: directed table, then random raster phases.
// Depends on rgbyuv_pkg, the three channel interfaces and the converter RTL.
`timescale 1ns / 100ps

module tb;
    import rgbyuv_pkg::*;

    localparam int LINE_MAX    = MAX_WIDTH_DEF;
    localparam int ITEM_TARGET = 1550;
    localparam int SETTLE      = 10;
    localparam int DRAIN       = 20;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

    typedef struct packed {
        logic [COMP_W-1:0] luma;
        logic              chroma_valid;
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
        logic              row_end;
    } yuv_result_t;

    typedef enum logic [1:0] {
        DO_WRITE,
        DO_PIXEL
    } step_kind_t;

    typedef struct packed {
        step_kind_t              kind;
        logic [CFG_IDX_W-1:0]    reg_index;
        logic [CFG_DATA_W-1:0]   reg_data;
        rgb_t                    pix;
        logic                    typed;
        yuv_result_t             want;
    } script_row_t;

    localparam rgb_t        NO_PIXEL  = '0;
    localparam yuv_result_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;

    rgbyuv_pix_if pix_ch();
    rgbyuv_res_if yuv_ch();
    rgbyuv_cfg_if cfg_ch();

    rgb_to_yuv420_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (yuv_ch),
        .cfg     (cfg_ch)
    );

    // Converter state as seen by the predictor
    rgb_t line_mem [LINE_MAX];
    bit   written  [LINE_MAX];
    int   col_pos;
    bit   odd_row;
    rgb_t held_avg;
    int   width_reg;
    bit   full_reg;

    yuv_result_t expected_yuv [$];
    yuv_result_t seen;
    yuv_result_t wanted;
    int          errors;
    int          cycles;
    int          pixels_sent;
    bit          steady;

    // Directed rows: typed results are black, white, red, blue, green and a gray block
    script_row_t script_rows [0:28] = '{
        '{DO_WRITE, REG_ROW_WIDTH,  13'd3, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_WRITE, REG_FULL_RANGE, 13'd0, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd16, 1'b0, 8'd0, 8'd0, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd235, 1'b0, 8'd0, 8'd0, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b1,
          '{8'd82, 1'b0, 8'd0, 8'd0, 1'b1}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd0, 8'd0, 8'd0}, 1'b1,
          '{8'd16, 1'b0, 8'd0, 8'd0, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd235, 1'b1, 8'd128, 8'd128, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd0, 8'd0}, 1'b1,
          '{8'd82, 1'b1, 8'd90, 8'd239, 1'b1}},
        '{DO_WRITE, REG_FULL_RANGE, 13'd1, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b1,
          '{8'd30, 1'b0, 8'd0, 8'd0, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd0, 8'd255, 8'd0}, 1'b1,
          '{8'd149, 1'b0, 8'd0, 8'd0, 1'b0}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd255, 8'd255}, 1'b1,
          '{8'd255, 1'b0, 8'd0, 8'd0, 1'b1}},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd255, 8'd255, 8'd0}, 1'b0, NO_RESULT},
        // mode flips between the two halves of a block
        '{DO_WRITE, REG_FULL_RANGE, 13'd0, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd128, 8'd64, 8'd200}, 1'b0, NO_RESULT},
        // zero width acts as one pixel per row
        '{DO_WRITE, REG_ROW_WIDTH, 13'd0, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd10, 8'd20, 8'd30}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd200, 8'd100, 8'd50}, 1'b0, NO_RESULT},
        // shrink the width mid-row: the next pixel closes the row
        '{DO_WRITE, REG_ROW_WIDTH, 13'd6, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd1, 8'd254, 8'd127}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd128, 8'd2, 8'd253}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd85, 8'd170, 8'd4}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd170, 8'd85, 8'd251}, 1'b0, NO_RESULT},
        '{DO_WRITE, REG_ROW_WIDTH, 13'd2, NO_PIXEL, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd16, 8'd32, 8'd64}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd240, 8'd8, 8'd99}, 1'b0, NO_RESULT},
        '{DO_PIXEL, 4'd0, 13'd0, '{8'd7, 8'd200, 8'd15}, 1'b0, NO_RESULT},
        // write to an unmapped index is ignored
        '{DO_WRITE, REG_UNUSED, 13'h1FFF, NO_PIXEL, 1'b0, NO_RESULT}
    };

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int effective_width(int w);
        if (w == 0)
            return 1;
        if (w > LINE_MAX)
            return LINE_MAX;
        return w;
    endfunction

    function automatic rgb_t blend(rgb_t a, rgb_t b);
        rgb_t m;
        m.red   = 8'((int'(a.red) + int'(b.red) + 1) >> 1);
        m.green = 8'((int'(a.green) + int'(b.green) + 1) >> 1);
        m.blue  = 8'((int'(a.blue) + int'(b.blue) + 1) >> 1);
        return m;
    endfunction

    function automatic logic [COMP_W-1:0] luma_of(rgb_t p, bit full);
        int r;
        int g;
        int b;
        int s;
        r = p.red;
        g = p.green;
        b = p.blue;
        if (full)
            s = (38 * r + 75 * g + 15 * b + 64) >> 7;
        else
            s = (66 * r + 129 * g + 25 * b + 'h1080) >> 8;
        return s[7:0];
    endfunction

    // Returns {cb, cr}
    function automatic logic [15:0] chroma_of(rgb_t p, bit full);
        int r;
        int g;
        int b;
        int u;
        int v;
        r = p.red;
        g = p.green;
        b = p.blue;
        if (full)
        begin
            u = 127 * b - 84 * g - 43 * r + 'h8080;
            v = 127 * r - 107 * g - 20 * b + 'h8080;
        end
        else
        begin
            u = 112 * b - 74 * g - 38 * r + 'h8000;
            v = 112 * r - 94 * g - 18 * b + 'h8000;
        end
        return {u[15:8], v[15:8]};
    endfunction

    // Expected result of one pixel; advances the raster position
    function automatic yuv_result_t convert_pixel(rgb_t px);
        yuv_result_t res_v;
        rgb_t        vert;
        int          weff;
        bit          last;
        weff = effective_width(width_reg);
        last = (col_pos + 1 >= weff);
        res_v = '0;
        res_v.luma = luma_of(px, full_reg);
        res_v.row_end = last;
        if (!odd_row)
        begin
            line_mem[col_pos] = px;
            written[col_pos] = 1'b1;
        end
        else
        begin
            vert = blend(line_mem[col_pos], px);
            if (col_pos[0] == 1'b0)
            begin
                held_avg = vert;
                if (last)
                begin
                    {res_v.cb, res_v.cr} = chroma_of(vert, full_reg);
                    res_v.chroma_valid = 1'b1;
                end
            end
            else
            begin
                {res_v.cb, res_v.cr} = chroma_of(blend(held_avg, vert), full_reg);
                res_v.chroma_valid = 1'b1;
            end
        end
        if (last)
        begin
            col_pos = 0;
            odd_row = !odd_row;
        end
        else
            col_pos = col_pos + 1;
        return res_v;
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 6)
            return 8191;
        if (r < 8)
            return 4096;
        if (r < 9)
            return 4097;
        if (r < 12)
            return 1;
        if (r < 70)
            return $urandom_range(2, 8);
        if (r < 95)
            return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // One pixel transfer; the expectation is queued at the accepting edge
    task automatic put_pixel(rgb_t px, logic typed, yuv_result_t want);
        int          gap;
        yuv_result_t got;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= px.red;
        pix_ch.green <= px.green;
        pix_ch.blue  <= px.blue;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        got = convert_pixel(px);
        expected_yuv.push_back(typed ? want : got);
        pixels_sent++;
    endtask

    task automatic drop_pixel_valid();
        if (pix_ch.valid)
        begin
            @(negedge clk);
            pix_ch.valid <= 1'b0;
        end
    endtask

    // Register write, only once the converter has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drop_pixel_valid();
        while (expected_yuv.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_ROW_WIDTH)
            width_reg = int'(val);
        else if (idx == REG_FULL_RANGE)
            full_reg = val[0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side back-pressure
    initial
    begin
        int g;
        yuv_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = steady ? 0 : pick_gap();
            if (g > 0)
            begin
                @(negedge clk);
                yuv_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            @(negedge clk);
            yuv_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && yuv_ch.valid && yuv_ch.ready)
        begin
            seen = {yuv_ch.luma, yuv_ch.chroma_valid, yuv_ch.cb, yuv_ch.cr, yuv_ch.row_end};
            if (expected_yuv.size() == 0)
            begin
                $display("%0t: result with nothing pending: luma=%0d cv=%0d cb=%0d cr=%0d end=%0d",
                         $time, seen.luma, seen.chroma_valid, seen.cb, seen.cr, seen.row_end);
                errors++;
            end
            else
            begin
                wanted = expected_yuv.pop_front();
                if (seen !== wanted)
                begin
                    $display("%0t: mismatch expected luma=%0d cv=%0d cb=%0d cr=%0d end=%0d",
                             $time, wanted.luma, wanted.chroma_valid, wanted.cb, wanted.cr,
                             wanted.row_end);
                    $display("%0t:          actual   luma=%0d cv=%0d cb=%0d cr=%0d end=%0d",
                             $time, seen.luma, seen.chroma_valid, seen.cb, seen.cr,
                             seen.row_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, expected_yuv.size());
            $display("** rgb_to_yuv420_converter: FAILED **");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int   phase;
        int   w;
        int   weff;
        int   ext;
        int   first;
        int   n;
        rgb_t px;

        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        errors = 0;
        cycles = 0;
        pixels_sent = 0;
        steady = 1'b0;
        col_pos = 0;
        odd_row = 1'b0;
        held_avg = '0;
        width_reg = int'(ROW_WIDTH_RESET);
        full_reg = 1'b0;
        for (int i = 0; i < LINE_MAX; i++)
            written[i] = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table
        foreach (script_rows[i])
        begin
            if (script_rows[i].kind == DO_WRITE)
                write_reg(script_rows[i].reg_index, script_rows[i].reg_data);
            else
                put_pixel(script_rows[i].pix, script_rows[i].typed, script_rows[i].want);
        end

        // Random raster phases; first two force the widest and narrowest rows
        phase = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            if (phase == 0)
                w = 8191;
            else if (phase == 1)
                w = 1;
            else
                w = pick_width();
            if (phase < 2 || $urandom_range(0, 2) != 0)
            begin
                // an odd row may not run past what the even row above stored
                if (odd_row)
                begin
                    ext = col_pos;
                    while (ext < LINE_MAX && written[ext])
                        ext++;
                    if (ext < 1)
                        ext = 1;
                    if (effective_width(w) > ext)
                        w = ext;
                end
                write_reg(REG_ROW_WIDTH, w[CFG_DATA_W-1:0]);
            end
            if (phase < 2 || $urandom_range(0, 2) == 0)
                write_reg(REG_FULL_RANGE, CFG_DATA_W'($urandom_range(0, 1)));

            weff = effective_width(width_reg);
            steady = ($urandom_range(0, 3) == 0);
            first = (col_pos >= weff) ? 1 : weff - col_pos;
            if (!odd_row)
                first += weff;
            if (weff > 200)
                n = $urandom_range(20, 150);
            else if ($urandom_range(0, 3) != 0)
                n = first + 2 * weff * $urandom_range(0, (weff > 40) ? 1 : 3);
            else
                n = $urandom_range(1, 2 * weff + 2);
            // stop close to the item target
            if (n > ITEM_TARGET - pixels_sent)
                n = ITEM_TARGET - pixels_sent;

            repeat (n)
            begin
                px.red   = pick_comp();
                px.green = pick_comp();
                px.blue  = pick_comp();
                put_pixel(px, 1'b0, NO_RESULT);
            end
            phase++;
        end

        // Drain
        drop_pixel_valid();
        steady = 1'b0;
        while (expected_yuv.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (errors == 0)
            $display("** rgb_to_yuv420_converter: PASSED **");
        else
            $display("** rgb_to_yuv420_converter: FAILED **");
        $finish;
    end

endmodule

### rgb_to_yuv420_converter.f
rtl/rgbyuv_pkg.sv
rtl/rgbyuv_pix_if.sv
rtl/rgbyuv_res_if.sv
rtl/rgbyuv_cfg_if.sv
rtl/rgbyuv_front.sv
rtl/rgbyuv_queue.sv
rtl/rgbyuv_back.sv
rtl/rgb_to_yuv420_converter.sv
rtl/rgbyuv_checker.sv
sim/tb.sv
